/* src/lbs_pkg.sv */
package lbs_pkg;

	localparam int DefMaxJoints     = 256;
	localparam int DefMaxInfluences = 8;
	localparam int DefFracBits      = 16;
	localparam int WeightBits       = 16;
	localparam int NrmOneBits       = 16;
	localparam int ElemCount        = 12;

	localparam logic FuncLoad      = 1'b0;
	localparam logic FuncInfluence = 1'b1;

	localparam logic signed [63:0] Int32Max = 64'sd2147483647;
	localparam logic signed [63:0] Int32Min = -64'sd2147483648;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > Int32Max) r = 32'sh7fffffff;
		else if (v < Int32Min) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// control word from the sequencer to the shared multiplier
	typedef struct packed {
		logic               start;
		logic signed [32:0] a;
		logic signed [32:0] b;
	} lbs_mul_req_t;

endpackage

/* src/lbs_mul.sv */
// shared signed multiplier, one registered product per cycle
module lbs_mul (
	input  logic                     clk,
	input  lbs_pkg::lbs_mul_req_t    req,
	output logic signed [65:0]       prod_q
);
	import lbs_pkg::*;

	// product register
	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= req.a * req.b;
		end
	end
endmodule

/* src/lbs_div.sv */
// shift-subtract divider and square root, one bit per cycle
module lbs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_sqrt,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done_q,
	output logic [63:0] res_q
);
	import lbs_pkg::*;

	logic        busy_q;
	logic        sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [65:0] rem_q;
	logic [31:0] den_q;
	logic [65:0] trial;
	logic [65:0] rem_sh;

	// next remainder candidates
	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[63:0], x_q[63:62]};
			trial  = {res_q[63:0], 2'b01};
		end else begin
			rem_sh = {rem_q[64:0], x_q[63]};
			trial  = {34'd0, den_q};
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sqrt_q <= is_sqrt;
			x_q    <= num;
			den_q  <= den;
			rem_q  <= '0;
			res_q  <= '0;
			cnt_q  <= is_sqrt ? 6'd31 : 6'd63;
		end else if (busy_q) begin
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				res_q <= {res_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				res_q <= {res_q[62:0], 1'b0};
			end
			x_q   <= sqrt_q ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
			cnt_q <= cnt_q - 6'd1;
		end
	end
endmodule

/* src/linear_blend_vertex_skinning_unit.sv */
// channel | valid    | stall    | word
// in      | in_valid | in_stall | func .. last_influence
// out     | out_valid| out_stall| out_pos_*, out_nrm_*
// a load is written on accept and the block stays in S_IDLE; an influence that is
// not skipped (zero weight, stopped vertex or full count) runs the 12 matrix reads
// and the 24 products on the shared multiplier. a last influence adds the normalize:
// 32 root steps and 3 x 64 divide steps. the matrix table has one write and one read port.
// reset clears the accumulators and flags; the table stays undefined.
// the block takes no word while busy; a finished vertex waits in S_OUT while
// the previous result is held by out_stall.
module linear_blend_vertex_skinning_unit
	import lbs_pkg::*;
#(
	parameter int MAX_JOINTS     = DefMaxJoints,
	parameter int MAX_INFLUENCES = DefMaxInfluences,
	parameter int FRAC_BITS      = DefFracBits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [7:0]         joint_index,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] matrix_value,
	input  logic [16:0]        weight,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] nrm_x,
	input  logic signed [31:0] nrm_y,
	input  logic signed [31:0] nrm_z,
	input  logic               last_influence,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [17:0] out_nrm_x,
	output logic signed [17:0] out_nrm_y,
	output logic signed [17:0] out_nrm_z
);
	localparam int Depth   = MAX_JOINTS * ElemCount;
	localparam int AddrW   = $clog2(Depth);
	localparam int CntW    = $clog2(MAX_INFLUENCES + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RDW, S_MUL, S_MULW, S_ACC, S_WMUL, S_WACC,
		S_NMAG, S_NSQ, S_NSQW, S_ROOT, S_DIV, S_DIVW, S_OUT
	} state_t;

	state_t state_q;

	// matrix memory
	logic signed [31:0] mem [Depth];
	logic signed [31:0] rd_q;
	logic               we;
	logic [AddrW-1:0]   waddr;
	logic [AddrW-1:0]   raddr_q;

	assign waddr = AddrW'(32'(joint_index) * ElemCount + 32'(element_index));
	assign we = in_valid && !in_stall && func == FuncLoad &&
		32'(joint_index) < MAX_JOINTS && element_index < 4'(ElemCount);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= matrix_value;
		rd_q <= mem[raddr_q];
	end

	// captured item
	logic signed [31:0] p_q [3];
	logic signed [31:0] n_q [3];
	logic [16:0]        w_q;
	logic               last_q;
	logic               jok_q;
	logic signed [63:0] pacc_q [3];
	logic signed [63:0] nacc_q [3];
	logic               stopped_q;
	logic [CntW-1:0]    cnt_q;

	// per-row working values
	logic [1:0]         row_q;
	logic [2:0]         col_q;
	logic               side_q;   // 0 position, 1 normal
	logic signed [63:0] tp_q;
	logic signed [63:0] tn_q;
	logic signed [31:0] m_q [4];

	// normalize state
	logic [63:0] mag_q [3];
	logic [2:0]  neg_q;
	logic [63:0] ssum_q;
	logic [31:0] len_q;
	logic [17:0] nout_q [3];
	logic [1:0]  idx_q;

	// shared multiplier
	lbs_mul_req_t       mreq;
	logic signed [65:0] prod;
	lbs_mul u_mul (.clk(clk), .req(mreq), .prod_q(prod));

	// shared divider / root
	logic        d_start;
	logic        d_sqrt;
	logic [63:0] d_num;
	logic        d_done;
	logic [63:0] d_res;
	lbs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .is_sqrt(d_sqrt),
		.num(d_num), .den(len_q), .done_q(d_done), .res_q(d_res)
	);

	// floor shift of a product by the fraction width
	logic signed [65:0] prod_sh;
	assign prod_sh = prod >>> FRAC_BITS;

	// highest set bit of the largest magnitude
	logic [63:0] mmax;
	logic [5:0]  msb_c;
	always_comb begin
		mmax = mag_q[0];
		if (mag_q[1] > mmax) mmax = mag_q[1];
		if (mag_q[2] > mmax) mmax = mag_q[2];
		msb_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (mmax[i]) msb_c = 6'(i);
		end
	end

	// multiplier operand select
	always_comb begin
		mreq = '0;
		if (state_q == S_MUL) begin
			mreq.start = 1'b1;
			mreq.a = 33'(m_q[col_q[1:0]]);
			mreq.b = side_q ? 33'(n_q[col_q[1:0]]) : 33'(p_q[col_q[1:0]]);
		end else if (state_q == S_WMUL) begin
			mreq.start = 1'b1;
			mreq.a = side_q ? 33'(sat32(tn_q)) : 33'(sat32(tp_q));
			mreq.b = 33'($signed({16'd0, w_q}));
		end else if (state_q == S_NSQ) begin
			mreq.start = 1'b1;
			mreq.a = $signed({1'b0, mag_q[idx_q][31:0]});
			mreq.b = $signed({1'b0, mag_q[idx_q][31:0]});
		end
	end

	assign d_start = (state_q == S_ROOT && !col_q[2]) || (state_q == S_DIV);
	assign d_sqrt  = state_q == S_ROOT;
	assign d_num   = d_sqrt ? ssum_q : {mag_q[idx_q][47:0], 16'd0};

	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			stopped_q <= 1'b0;
			cnt_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				pacc_q[i] <= '0;
				nacc_q[i] <= '0;
			end
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall && func == FuncInfluence) begin
						p_q[0] <= pos_x; p_q[1] <= pos_y; p_q[2] <= pos_z;
						n_q[0] <= nrm_x; n_q[1] <= nrm_y; n_q[2] <= nrm_z;
						w_q <= weight;
						last_q <= last_influence;
						jok_q <= 32'(joint_index) < MAX_JOINTS;
						row_q <= '0;
						col_q <= '0;
						raddr_q <= AddrW'(32'(joint_index) * ElemCount);
						if (weight == 17'd0 || stopped_q ||
							32'(cnt_q) >= MAX_INFLUENCES) begin
							if (weight == 17'd0) stopped_q <= 1'b1;
							state_q <= last_influence ? S_NMAG : S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				// read four elements of one row
				S_RD: begin
					raddr_q <= raddr_q + 1'b1;
					state_q <= S_RDW;
				end
				S_RDW: begin
					m_q[col_q[1:0]] <= jok_q ? rd_q : 32'sd0;
					if (col_q == 3'd3) begin
						col_q <= '0;
						side_q <= 1'b0;
						tp_q <= 64'(jok_q ? rd_q : 32'sd0);
						tn_q <= '0;
						state_q <= S_MUL;
					end else begin
						col_q <= col_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_MUL: state_q <= S_MULW;
				S_MULW: begin
					if (side_q) tn_q <= tn_q + 64'(prod_sh);
					else tp_q <= tp_q + 64'(prod_sh);
					if (side_q && col_q == 3'd2) begin
						side_q <= 1'b0;
						state_q <= S_WMUL;
					end else begin
						if (side_q) col_q <= col_q + 1'b1;
						side_q <= !side_q;
						state_q <= S_MUL;
					end
				end
				S_WMUL: state_q <= S_WACC;
				S_WACC: begin
					if (side_q) nacc_q[row_q] <= nacc_q[row_q] + 64'(prod >>> WeightBits);
					else pacc_q[row_q] <= pacc_q[row_q] + 64'(prod >>> WeightBits);
					if (!side_q) begin
						side_q <= 1'b1;
						state_q <= S_WMUL;
					end else if (row_q == 2'd2) begin
						state_q <= last_q ? S_NMAG : S_IDLE;
					end else begin
						row_q <= row_q + 1'b1;
						col_q <= '0;
						state_q <= S_RD;
					end
				end
				// magnitudes and signs
				S_NMAG: begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= nacc_q[i][63];
						mag_q[i] <= nacc_q[i][63] ? 64'(-nacc_q[i]) : nacc_q[i];
					end
					col_q <= '0;
					idx_q <= '0;
					ssum_q <= '0;
					state_q <= S_NSQ;
				end
				S_NSQ: begin
					if (col_q == 3'd0) begin
						// scale so the top bit sits at bit 30
						col_q <= 3'd1;
						if (mmax == 64'd0) begin
							for (int i = 0; i < 3; i++) nout_q[i] <= '0;
							state_q <= S_OUT;
						end else begin
							for (int i = 0; i < 3; i++) begin
								mag_q[i] <= (msb_c > 6'd30) ? mag_q[i] >> (msb_c - 6'd30)
									: mag_q[i] << (6'd30 - msb_c);
							end
						end
					end else begin
						state_q <= S_NSQW;
					end
				end
				S_NSQW: begin
					ssum_q <= ssum_q + 64'(prod);
					if (idx_q == 2'd2) begin
						col_q <= '0;
						state_q <= S_ROOT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_NSQ;
					end
				end
				S_ROOT: begin
					col_q <= 3'd4;
					if (d_done) begin
						len_q <= d_res[31:0];
						idx_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (d_done) begin
						nout_q[idx_q] <= neg_q[idx_q] ? 18'(-d_res) : 18'(d_res);
						if (idx_q == 2'd2) state_q <= S_OUT;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				// wait until the result register is free
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_pos_x <= sat32(pacc_q[0]);
						out_pos_y <= sat32(pacc_q[1]);
						out_pos_z <= sat32(pacc_q[2]);
						out_nrm_x <= nout_q[0];
						out_nrm_y <= nout_q[1];
						out_nrm_z <= nout_q[2];
						for (int i = 0; i < 3; i++) begin
							pacc_q[i] <= '0;
							nacc_q[i] <= '0;
						end
						stopped_q <= 1'b0;
						cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pos_x))
		else $error("result lost");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_INFLUENCES) else $error("influence count overflow");
	a_nrm_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $signed(out_nrm_x) <= 18'sd65536 &&
		$signed(out_nrm_x) >= -18'sd65536) else $error("normal out of range");
endmodule

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lbs_pkg::*;

	// one input word as the sender drives it
	typedef struct packed {
		logic               f;
		logic [7:0]         j;
		logic [3:0]         e;
		logic signed [31:0] mv;
		logic [16:0]        w;
		logic signed [31:0] px, py, pz;
		logic signed [31:0] nx, ny, nz;
		logic               last;
	} skin_word_t;

	// one skinned vertex
	typedef struct packed {
		logic signed [31:0] px, py, pz;
		logic signed [17:0] nx, ny, nz;
	} skinned_vtx_t;

	// directed row, with an optional typed-in vertex
	typedef struct packed {
		skin_word_t   wd;
		logic         typed;
		skinned_vtx_t vtx;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [7:0]         joint_index;
	logic [3:0]         element_index;
	logic signed [31:0] matrix_value;
	logic [16:0]        weight;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [31:0] nrm_x, nrm_y, nrm_z;
	logic               last_influence;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [17:0] out_nrm_x, out_nrm_y, out_nrm_z;

	linear_blend_vertex_skinning_unit u_dut (.*);

	// predictor state
	logic signed [31:0] joint_mat [0:DefMaxJoints*ElemCount-1];
	bit [11:0]          joint_loaded [0:DefMaxJoints-1];
	longint             pos_acc [3];
	longint             nrm_acc [3];
	bit                 vtx_stopped;
	int unsigned        vtx_infl;

	skinned_vtx_t vertex_q [$];
	dir_row_t     dir_tab [$];
	int           mismatches;
	int           n_loads, n_infl, n_vertices, n_zero_nrm, n_checked;
	bit           calm;

	initial begin
		clk = 1'b0;
	end
	always #4 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned r = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit normal from the normal sums, zero stays zero
	function automatic void unit_normal(output logic signed [17:0] o [3]);
		longint unsigned mag [3];
		bit              neg [3];
		longint unsigned top, sq, len, q;
		int              msb;
		top = 0;
		sq = 0;
		msb = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = nrm_acc[i] < 0;
			mag[i] = neg[i] ? -nrm_acc[i] : nrm_acc[i];
			if (mag[i] > top) top = mag[i];
		end
		if (top == 0) begin
			for (int i = 0; i < 3; i++) o[i] = '0;
			return;
		end
		while (msb < 63 && (top >> (msb + 1)) != 0) msb++;
		for (int i = 0; i < 3; i++) begin
			if (msb > 30) mag[i] >>= (msb - 30);
			else mag[i] <<= (30 - msb);
			sq += mag[i] * mag[i];
		end
		len = floor_root(sq);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] << NrmOneBits) / len;
			if (neg[i]) q = -q;
			o[i] = q[17:0];
		end
	endfunction

	// apply one accepted word to the predictor, queue a vertex on the last influence
	task automatic blend_word(input skin_word_t wd, input logic typed, input skinned_vtx_t tv);
		longint       p [3];
		longint       n [3];
		longint       m [4];
		longint       tp, tn;
		logic signed [17:0] u [3];
		skinned_vtx_t v;
		if (wd.f == FuncLoad) begin
			n_loads++;
			if (wd.e < ElemCount) begin
				joint_mat[wd.j*ElemCount + wd.e] = wd.mv;
				joint_loaded[wd.j][wd.e] = 1'b1;
			end
			return;
		end
		n_infl++;
		p[0] = wd.px; p[1] = wd.py; p[2] = wd.pz;
		n[0] = wd.nx; n[1] = wd.ny; n[2] = wd.nz;
		if (wd.w == 0) vtx_stopped = 1'b1;
		if (!vtx_stopped && vtx_infl < DefMaxInfluences) begin
			vtx_infl++;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) m[c] = joint_mat[wd.j*ElemCount + r*4 + c];
				tp = m[3];
				tn = 0;
				for (int c = 0; c < 3; c++) begin
					tp += (m[c] * p[c]) >>> DefFracBits;
					tn += (m[c] * n[c]) >>> DefFracBits;
				end
				tp = clamp32(tp);
				tn = clamp32(tn);
				pos_acc[r] += (tp * longint'(wd.w)) >>> WeightBits;
				nrm_acc[r] += (tn * longint'(wd.w)) >>> WeightBits;
			end
		end
		if (!wd.last) return;
		v.px = clamp32(pos_acc[0]);
		v.py = clamp32(pos_acc[1]);
		v.pz = clamp32(pos_acc[2]);
		unit_normal(u);
		v.nx = u[0]; v.ny = u[1]; v.nz = u[2];
		if (u[0] == 0 && u[1] == 0 && u[2] == 0) n_zero_nrm++;
		vertex_q.push_back(typed ? tv : v);
		n_vertices++;
		for (int r = 0; r < 3; r++) begin
			pos_acc[r] = 0;
			nrm_acc[r] = 0;
		end
		vtx_stopped = 1'b0;
		vtx_infl = 0;
	endtask

	// drive one word and hold it until taken
	task automatic send_word(input skin_word_t wd, input logic typed, input skinned_vtx_t tv);
		if (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= wd.f;
		joint_index    <= wd.j;
		element_index  <= wd.e;
		matrix_value   <= wd.mv;
		weight         <= wd.w;
		pos_x          <= wd.px;
		pos_y          <= wd.py;
		pos_z          <= wd.pz;
		nrm_x          <= wd.nx;
		nrm_y          <= wd.ny;
		nrm_z          <= wd.nz;
		last_influence <= wd.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		blend_word(wd, typed, tv);
	endtask

	function automatic logic signed [31:0] rand_coord(input bit wide);
		case ($urandom_range(wide ? 9 : 19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3, 4, 5: return $urandom;
			default: return $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh20_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_elem();
		case ($urandom_range(19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			3: return 32'sh0001_0000;
			default: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
		endcase
	endfunction

	function automatic logic [16:0] rand_weight();
		case ($urandom_range(19))
			0, 1: return 17'd0;
			2, 3: return 17'd65536;
			4: return 17'd1;
			default: return 17'($urandom_range(1, 65536));
		endcase
	endfunction

	function automatic skin_word_t rand_noise();
		skin_word_t wd;
		wd.f = FuncLoad;
		wd.j = 8'($urandom);
		wd.e = 4'($urandom);
		wd.mv = rand_elem();
		wd.w = 17'($urandom_range(0, 65536));
		wd.px = $urandom; wd.py = $urandom; wd.pz = $urandom;
		wd.nx = $urandom; wd.ny = $urandom; wd.nz = $urandom;
		wd.last = 1'($urandom);
		return wd;
	endfunction

	function automatic skin_word_t mk_load(input logic [7:0] j, input logic [3:0] e,
			input logic signed [31:0] v);
		skin_word_t wd;
		wd = '0;
		wd.f = FuncLoad;
		wd.j = j;
		wd.e = e;
		wd.mv = v;
		return wd;
	endfunction

	function automatic skin_word_t mk_infl(input logic [7:0] j, input logic [16:0] w,
			input logic signed [31:0] px, py, pz, nx, ny, nz, input logic last);
		skin_word_t wd;
		wd = '0;
		wd.f = FuncInfluence;
		wd.j = j;
		wd.w = w;
		wd.px = px; wd.py = py; wd.pz = pz;
		wd.nx = nx; wd.ny = ny; wd.nz = nz;
		wd.last = last;
		return wd;
	endfunction

	// result side: check each taken word, stall at random
	always @(posedge clk) begin
		skinned_vtx_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z};
			if (vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected vertex: pos %0d %0d %0d nrm %0d %0d %0d",
						got.px, got.py, got.pz, got.nx, got.ny, got.nz);
			end else begin
				want = vertex_q.pop_front();
				n_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("vertex %0d mismatch", n_checked);
						$display("  exp pos %0d %0d %0d nrm %0d %0d %0d",
							want.px, want.py, want.pz, want.nx, want.ny, want.nz);
						$display("  got pos %0d %0d %0d nrm %0d %0d %0d",
							got.px, got.py, got.pz, got.nx, got.ny, got.nz);
					end
				end
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 29);
	end

	// run limit
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// stimulus
	initial begin
		skin_word_t   wd;
		skinned_vtx_t nv;
		logic [7:0]   ready [$];
		logic [7:0]   jj;
		int           sent, n_inf;
		logic [3:0]   ord [$];

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		{func, joint_index, element_index, matrix_value, weight} = '0;
		{pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_influence} = '0;
		calm = 1'b0;
		mismatches = 0;
		for (int i = 0; i < DefMaxJoints; i++) joint_loaded[i] = '0;
		for (int i = 0; i < DefMaxJoints*ElemCount; i++) joint_mat[i] = '0;
		for (int r = 0; r < 3; r++) begin
			pos_acc[r] = 0;
			nrm_acc[r] = 0;
		end
		vtx_stopped = 1'b0;
		vtx_infl = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity on joint 0, then the special cases
		nv = '0;
		for (int e = 0; e < ElemCount; e++)
			dir_tab.push_back('{mk_load(8'd0, 4'(e), (e % 5 == 0) ? 32'sh1_0000 : 0),
				1'b0, nv});
		dir_tab.push_back('{mk_load(8'd0, 4'd15, 32'sh80000000), 1'b0, nv});
		dir_tab.push_back('{mk_load(8'd0, 4'd12, 32'sh7fffffff), 1'b0, nv});
		dir_tab.push_back('{mk_infl(8'd0, 17'd65536, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000,
			0, 0, 32'sh5_0000, 1'b1), 1'b1,
			skinned_vtx_t'{32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 0, 0, 18'sd65536}});
		dir_tab.push_back('{mk_infl(8'd0, 17'd65536, 32'sh7fffffff, 32'sh80000000, 0,
			0, 0, 0, 1'b1), 1'b1,
			skinned_vtx_t'{32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0}});
		dir_tab.push_back('{mk_infl(8'd0, 17'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh1_0000, 0, 0, 1'b1), 1'b1, nv});
		dir_tab.push_back('{mk_infl(8'd0, 17'd65536, 32'sh1_0000, 0, 0,
			0, 32'sh80000000, 0, 1'b0), 1'b0, nv});
		dir_tab.push_back('{mk_infl(8'd0, 17'd0, 32'sh5_0000, 0, 0, 32'sh1_0000, 0, 0, 1'b0),
			1'b0, nv});
		dir_tab.push_back('{mk_infl(8'd0, 17'd65536, 32'sh7_0000, 0, 0, 0, 0, 32'sh1_0000,
			1'b1), 1'b0, nv});
		dir_tab.push_back('{mk_infl(8'd0, 17'd1, 32'sh80000000, 32'sh7fffffff, 32'sh1,
			32'sh7fffffff, 32'sh80000000, 32'sh3_0000, 1'b1), 1'b0, nv});
		dir_tab.push_back('{mk_infl(8'd0, 17'd32768, -32'sh1_0000, 0, 32'sh4_0000,
			-32'sh3_0000, 32'sh4_0000, 0, 1'b1), 1'b0, nv});
		foreach (dir_tab[i]) send_word(dir_tab[i].wd, dir_tab[i].typed, dir_tab[i].vtx);
		sent = dir_tab.size();

		// random: matrix loads and whole vertices on loaded joints
		ready.push_back(8'd0);
		while (sent < 1500) begin
			calm = (sent >= 700 && sent < 850);
			if (sent >= 1100 && sent < 1112) begin
				in_valid <= 1'b0;
				wait (vertex_q.size() == 0);
				@(posedge clk);
			end
			case ($urandom_range(19))
				0, 1: begin
					// full matrix of a random joint, elements in shuffled order
					jj = (ready.size() < 4) ? 8'(255 - ready.size()) : 8'($urandom);
					ord.delete();
					for (int e = 0; e < ElemCount; e++) ord.push_back(4'(e));
					ord.shuffle();
					foreach (ord[k]) begin
						wd = rand_noise();
						wd.j = jj;
						wd.e = ord[k];
						send_word(wd, 1'b0, nv);
						sent++;
					end
					if (joint_loaded[jj] == 12'hfff) ready.push_back(jj);
				end
				2: begin
					// loose load, any element index
					send_word(rand_noise(), 1'b0, nv);
					sent++;
				end
				default: begin
					n_inf = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 4);
					for (int k = 0; k < n_inf; k++) begin
						wd = rand_noise();
						wd.f = FuncInfluence;
						wd.j = ready[$urandom_range(ready.size() - 1)];
						wd.w = rand_weight();
						wd.px = rand_coord(1'b0); wd.py = rand_coord(1'b0);
						wd.pz = rand_coord(1'b0);
						wd.nx = rand_coord(1'b1); wd.ny = rand_coord(1'b1);
						wd.nz = rand_coord(1'b1);
						if ($urandom_range(15) == 0) {wd.nx, wd.ny, wd.nz} = '0;
						wd.last = (k == n_inf - 1);
						send_word(wd, 1'b0, nv);
						sent++;
					end
				end
			endcase
		end
		in_valid <= 1'b0;

		// drain
		wait (vertex_q.size() == 0);
		repeat (400) @(posedge clk);
		$display("%0d matrix loads and %0d influences sent, %0d vertices checked",
			n_loads, n_infl, n_checked);
		$display("%0d zero normals, %0d joints fully loaded, %0d mismatches",
			n_zero_nrm, ready.size(), mismatches);
		if (mismatches == 0 && vertex_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
src/lbs_pkg.sv
src/lbs_mul.sv
src/lbs_div.sv
src/linear_blend_vertex_skinning_unit.sv
tb/tb_top.sv
